>>> sv/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types, constants and index helpers for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;

  // output tdata: popped, front, rear; output tuser: empty, full, status
  localparam int OUT_DATA_W = 3 * DATA_W;
  localparam int OUT_USER_W = 2 + STAT_W;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_PEEK       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_REAR  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_REAR   = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    word_t wdata;
    idx_t  raddr;
  } mem_req_t;

  typedef struct packed {
    status_e status;
    logic    full;
    logic    empty;
    word_t   rear;
    word_t   front;
    word_t   popped;
  } result_t;

  function automatic idx_t next_idx(idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t prev_idx(idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
  endfunction

endpackage

>>> sv/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Deque control: indices, end-value caches, sequencer and result register.
// ----------------------------------------------------------------------------
module cdq_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic signed [cdq_pkg::DATA_W-1:0] s_axis_tdata_i,
  input  logic [cdq_pkg::OP_W-1:0]      s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output cdq_pkg::result_t              result_o,
  output cdq_pkg::mem_req_t             mem_req_o,
  input  cdq_pkg::word_t                mem_rdata_i
);
  import cdq_pkg::*;

  state_e  state_q, state_d;
  idx_t    front_q, front_d, rear_q, rear_d;
  logic    empty_q, empty_d;
  word_t   fval_q, fval_d, rval_q, rval_d;
  logic    rd_front_q, rd_front_d;
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      rear_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fval_q     <= fval_d;
    rval_q     <= rval_d;
    rd_front_q <= rd_front_d;
    res_q      <= res_d;
  end

  always_comb begin
    op_e     op;
    logic    accept;
    logic    full_now;
    logic    need_rd;
    idx_t    nf, nr;
    logic    ne;
    word_t   fv, rv, popped;
    status_e stat;

    op       = op_e'(s_axis_tuser_i);
    full_now = !empty_q && (front_q == next_idx(rear_q));
    s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
    accept   = s_axis_tvalid_i && s_axis_tready_o;

    state_d     = state_q;
    front_d     = front_q;
    rear_d      = rear_q;
    empty_d     = empty_q;
    fval_d      = fval_q;
    rval_d      = rval_q;
    rd_front_d  = rd_front_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = '0;
    mem_req_o.wdata = word_t'(s_axis_tdata_i);
    mem_req_o.raddr = '0;

    nf      = front_q;
    nr      = rear_q;
    ne      = empty_q;
    fv      = fval_q;
    rv      = rval_q;
    popped  = '0;
    stat    = STAT_OK;
    need_rd = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op) inside
            OP_PEEK: begin
              if (empty_q) stat = STAT_UNDERFLOW;
            end
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
              if (full_now) begin
                stat = STAT_OVERFLOW;
              end else if (empty_q) begin
                nf = '0;
                nr = '0;
                ne = 1'b0;
                fv = word_t'(s_axis_tdata_i);
                rv = word_t'(s_axis_tdata_i);
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = '0;
              end else if (op == OP_PUSH_FRONT) begin
                nf = prev_idx(front_q);
                fv = word_t'(s_axis_tdata_i);
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = nf;
              end else begin
                nr = next_idx(rear_q);
                rv = word_t'(s_axis_tdata_i);
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = nr;
              end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
              if (empty_q) begin
                stat = STAT_UNDERFLOW;
              end else begin
                popped = (op == OP_POP_FRONT) ? fval_q : rval_q;
                if (front_q == rear_q) begin
                  nf = '0;
                  nr = '0;
                  ne = 1'b1;
                end else if (op == OP_POP_FRONT) begin
                  // new front value comes back from the RAM next cycle
                  nf = next_idx(front_q);
                  mem_req_o.raddr = nf;
                  need_rd    = 1'b1;
                  rd_front_d = 1'b1;
                end else begin
                  nr = prev_idx(rear_q);
                  mem_req_o.raddr = nr;
                  need_rd    = 1'b1;
                  rd_front_d = 1'b0;
                end
              end
            end
            default: ;
          endcase

          front_d = nf;
          rear_d  = nr;
          empty_d = ne;
          fval_d  = fv;
          rval_d  = rv;

          res_d.popped = popped;
          res_d.front  = ne ? '0 : fv;
          res_d.rear   = ne ? '0 : rv;
          res_d.empty  = ne;
          res_d.full   = !ne && (nf == next_idx(nr));
          res_d.status = stat;

          if (need_rd) begin
            state_d = ST_READ;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (rd_front_q) begin
          fval_d      = mem_rdata_i;
          res_d.front = mem_rdata_i;
        end else begin
          rval_d      = mem_rdata_i;
          res_d.rear  = mem_rdata_i;
        end
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign result_o        = res_q;

endmodule

>>> sv/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue over a circular RAM of DEPTH signed 32-bit words.
// ----------------------------------------------------------------------------
// Results are registered; a pop that leaves entries behind first passes through
//   the ST_READ state, since the new end value is read from the entry RAM.
// The input is not ready during that single RAM read, nor while a result stalls.
// Reset: asynchronous, active low; deque empty, indices zero. RAM contents
//   are not cleared; only entries written by pushes are ever read.
module circular_deque (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // data_in
  input  logic signed [cdq_pkg::DATA_W-1:0]  s_axis_tdata_i,
  // operation
  input  logic [cdq_pkg::OP_W-1:0]           s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // popped_value [31:0], front_value [63:32], rear_value [95:64]
  output logic [cdq_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // is_empty [0], is_full [1], status [3:2]
  output logic [cdq_pkg::OUT_USER_W-1:0]     m_axis_tuser_o
);
  import cdq_pkg::*;

  mem_req_t mem_req;
  word_t    mem_rdata;
  result_t  result;

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  cdq_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .result_o        (result),
    .mem_req_o       (mem_req),
    .mem_rdata_i     (mem_rdata)
  );

  assign m_axis_tdata_o = {result.rear, result.front, result.popped};
  assign m_axis_tuser_o = {result.status, result.full, result.empty};

endmodule

>>> sv/cdq_checker.sv
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks for the circular deque, bound to the top level.
// ----------------------------------------------------------------------------
module cdq_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [cdq_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  input logic [cdq_pkg::OUT_USER_W-1:0]     m_axis_tuser_o
);
  import cdq_pkg::*;

  // stalled result holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_empty_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |->
      m_axis_tdata_o[95:32] == '0 && !m_axis_tuser_o[1])
    else $error("empty deque reports values or full");

  a_refused_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[3:2] != STAT_OK |->
      m_axis_tdata_o[31:0] == '0)
    else $error("refused operation returned a popped value");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[3:2] == STAT_UNDERFLOW |-> m_axis_tuser_o[0])
    else $error("underflow on non-empty deque");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[3:2] == STAT_OVERFLOW |-> m_axis_tuser_o[1])
    else $error("overflow on non-full deque");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for circular_deque. Each operation accepted on the
// slave stream is run through a behavioral deque kept in the bench. The
// resulting snapshot (popped, front, rear, empty, full, status) is queued and
// compared field by field with the next master-stream transaction.
// ----------------------------------------------------------------------------
module testbench;
  import cdq_pkg::*;

  // unused operation codes; the block treats them as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam word_t WORD_MIN  = 32'h8000_0000;
  localparam word_t WORD_MAX  = 32'h7fff_ffff;
  localparam word_t WORD_ONES = 32'hffff_ffff;

  localparam int MAX_IDLE   = 15;
  localparam int HOLD_LONG  = 120;
  localparam int TAIL_WAIT  = 10;

  typedef struct {
    word_t   popped;
    word_t   front;
    word_t   rear;
    logic    empty;
    logic    full;
    status_e status;
  } deque_snapshot_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [DATA_W-1:0]     s_axis_tdata_i  = '0;
  logic [OP_W-1:0]       s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [OUT_USER_W-1:0] m_axis_tuser_o;

  circular_deque uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // behavioral deque
  word_t dq_slots [DEPTH];
  idx_t  dq_head  = '0;
  idx_t  dq_tail  = '0;
  logic  dq_empty = 1'b1;

  deque_snapshot_t snapshots_due[$];
  int   fail_count = 0;
  bit   no_idle    = 1'b0;
  int   hold_req   = 0;

  function automatic idx_t wrap_inc(idx_t i);
    return idx_t'((int'(i) + 1) % DEPTH);
  endfunction

  function automatic idx_t wrap_dec(idx_t i);
    return idx_t'((int'(i) + DEPTH - 1) % DEPTH);
  endfunction

  function automatic logic dq_is_full();
    return !dq_empty && (wrap_inc(dq_tail) == dq_head);
  endfunction

  function automatic deque_snapshot_t apply_deque_op(logic [OP_W-1:0] code, word_t data);
    deque_snapshot_t snap;
    snap.popped = '0;
    snap.status = STAT_OK;
    case (code)
      OP_PEEK: begin
        if (dq_empty) snap.status = STAT_UNDERFLOW;
      end
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (dq_is_full()) begin
          snap.status = STAT_OVERFLOW;
        end else if (dq_empty) begin
          dq_head     = '0;
          dq_tail     = '0;
          dq_empty    = 1'b0;
          dq_slots[0] = data;
        end else if (code == OP_PUSH_FRONT) begin
          dq_head           = wrap_dec(dq_head);
          dq_slots[dq_head] = data;
        end else begin
          dq_tail           = wrap_inc(dq_tail);
          dq_slots[dq_tail] = data;
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (dq_empty) begin
          snap.status = STAT_UNDERFLOW;
        end else begin
          snap.popped = dq_slots[(code == OP_POP_FRONT) ? dq_head : dq_tail];
          if (dq_head == dq_tail) begin
            // last entry gone: indices go back home
            dq_head  = '0;
            dq_tail  = '0;
            dq_empty = 1'b1;
          end else if (code == OP_POP_FRONT) begin
            dq_head = wrap_inc(dq_head);
          end else begin
            dq_tail = wrap_dec(dq_tail);
          end
        end
      end
      default: ;
    endcase
    snap.front = dq_empty ? '0 : dq_slots[dq_head];
    snap.rear  = dq_empty ? '0 : dq_slots[dq_tail];
    snap.empty = dq_empty;
    snap.full  = dq_is_full();
    return snap;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return WORD_ONES;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] rand_op(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    if (roll < 9) return OP_PEEK;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
    return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
  endfunction

  // Sender: returns at the edge where the transaction was accepted.
  task automatic offer_op(logic [OP_W-1:0] code, word_t data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= code;
    s_axis_tdata_i  <= data;
    do @(posedge clk_i); while (!s_axis_tready_o);
    snapshots_due.push_back(apply_deque_op(code, data));
  endtask

  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    while (snapshots_due.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: per-result stall plus an optional long hold-off
  initial begin : rx_side
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        stall_left = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  task automatic report_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    deque_snapshot_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (snapshots_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual data %h user %h",
                 $time, m_axis_tdata_o, m_axis_tuser_o);
        fail_count++;
      end else begin
        want = snapshots_due.pop_front();
        report_field("popped_value", want.popped, m_axis_tdata_o[DATA_W-1:0]);
        report_field("front_value", want.front, m_axis_tdata_o[2*DATA_W-1:DATA_W]);
        report_field("rear_value", want.rear, m_axis_tdata_o[3*DATA_W-1:2*DATA_W]);
        report_field("is_empty", DATA_W'(want.empty), DATA_W'(m_axis_tuser_o[0]));
        report_field("is_full", DATA_W'(want.full), DATA_W'(m_axis_tuser_o[1]));
        report_field("status", DATA_W'(want.status), DATA_W'(m_axis_tuser_o[3:2]));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_empty_deque();
    offer_op(OP_PEEK, WORD_ONES);
    offer_op(OP_POP_FRONT, '0);
    offer_op(OP_POP_REAR, WORD_MAX);
    offer_op(OP_SPARE_FIRST, WORD_MIN);
  endtask

  // push into empty, then take the only entry from either end
  task automatic test_single_entry();
    offer_op(OP_PUSH_REAR, WORD_MAX);
    offer_op(OP_POP_FRONT, '0);
    offer_op(OP_PUSH_FRONT, WORD_MIN);
    offer_op(OP_POP_REAR, '0);
  endtask

  // front pushes wrap the head below index zero; ends with refused pushes
  task automatic test_fill_to_overflow();
    word_t fill [4] = '{WORD_MIN, WORD_MAX, '0, WORD_ONES};
    for (int i = 0; i < DEPTH; i++)
      offer_op(i[0] ? OP_PUSH_FRONT : OP_PUSH_REAR, (i < 4) ? fill[i] : $urandom);
    offer_op(OP_PUSH_FRONT, $urandom);
    offer_op(OP_PUSH_REAR, $urandom);
  endtask

  // push bias shifts every few dozen items so the fill level sweeps
  task automatic test_random_walk(int count);
    int push_pct;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) push_pct = $urandom_range(15, 85);
      offer_op(rand_op(push_pct), rand_word());
    end
  endtask

  task automatic test_output_backpressure();
    no_idle  = 1'b1;
    hold_req = HOLD_LONG;
    test_random_walk(40);
    no_idle  = 1'b0;
  endtask

  task automatic test_pause_for_drain();
    test_random_walk(30);
    wait_for_results();
    test_random_walk(30);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_walk(300);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_deque();
    test_single_entry();
    test_fill_to_overflow();
    test_random_walk(700);
    test_output_backpressure();
    test_pause_for_drain();
    test_back_to_back();
    test_random_walk(250);
    wait_for_results();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
sv/cdq_pkg.sv
sv/cdq_ram.sv
sv/cdq_ctrl.sv
sv/circular_deque.sv
sv/cdq_checker.sv
tb/sv/testbench.sv
